@@ rtl/gps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gps_pkg - shared types and constants of the gradient path smoother
// Register map, fixed field widths and the control word of the update unit.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int WEIGHT_W   = 16;  // Q0.16 weights
  localparam int FRAC_BITS  = 16;  // fraction bits of a coordinate and a weight
  localparam int TOL_W      = 32;  // Q16.16 tolerance
  localparam int LIMIT_W    = 16;  // sweep limit and sweep counter
  localparam int SUM_W      = 40;  // saturating change accumulator
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [WEIGHT_W-1:0] DATA_WEIGHT_RST   = 16'd13107;
  localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST = 16'd52429;
  localparam logic [TOL_W-1:0]    STOP_TOL_RST      = 32'd66;
  localparam logic [LIMIT_W-1:0]  SWEEP_LIMIT_RST   = 16'd65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_WEIGHT   = 2'd0,
    REG_SMOOTH_WEIGHT = 2'd1,
    REG_STOP_TOL      = 2'd2,
    REG_SWEEP_LIMIT   = 2'd3
  } cfg_reg_t;

  // Steps of the shared multiply and update unit.
  typedef enum logic [2:0] {
    MAC_HOLD,
    MAC_DATA,
    MAC_SMOOTH,
    MAC_SAT,
    MAC_DELTA
  } mac_op_t;

  typedef struct packed {
    mac_op_t               op;
    logic [WEIGHT_W-1:0]   data_weight;
    logic [WEIGHT_W-1:0]   smooth_weight;
  } mac_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/gradient_path_smoother_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_path_smoother_top - gradient descent path smoother
// Loads a path one point per beat, smooths it by Gauss-Seidel sweeps through a
// shared multiply and update unit, then streams the smoothed points out.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   -------------------  ---------------------------------------------
//  input     start & !busy        in_coord_a, in_coord_b, in_final_point
//  result    out_valid (1 cycle)  out_smooth_a, out_smooth_b, out_run_end,
//                                 out_cap_hit
//  config    cfg_we               cfg_index, cfg_wdata
//
//  A non-final point leaves busy low. The final point starts the sweeps; busy
//  stays high until the last result beat has been issued. In a sweep every
//  interior coordinate passes five steps (data term, smoothing term,
//  saturation, absolute change, accumulation), the first two through the
//  single weight multiplier. The output phase issues one result beat per
//  cycle, limited by the single read port of the working store. Reset is
//  synchronous and active low and clears control state and the configuration
//  registers only; the point stores need no clearing, since every entry is
//  written before the current path reads it. The receiver cannot stall.
//
module gradient_path_smoother_top #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input channel
  input  wire                                  start,
  output logic                                 busy,
  input  wire logic signed [COORD_BITS-1:0]    in_coord_a,
  input  wire logic signed [COORD_BITS-1:0]    in_coord_b,
  input  wire                                  in_final_point,
  // result channel
  output logic                                 out_valid,
  output logic signed [COORD_BITS-1:0]         out_smooth_a,
  output logic signed [COORD_BITS-1:0]         out_smooth_b,
  output logic                                 out_run_end,
  output logic                                 out_cap_hit,
  // configuration port
  input  wire                                  cfg_we,
  input  wire [gps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [gps_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int CB = COORD_BITS;
  localparam int MW = 2 * CB;                         // one point: {b, a}
  localparam int CA = $clog2(MAX_POINTS);             // store address
  localparam int CW = $clog2(MAX_POINTS + 1);         // point count
  localparam int SW = ((CB + 1 > gps_pkg::SUM_W) ? CB + 1 : gps_pkg::SUM_W) + 1;
  localparam int MinPathLen = 3;                      // shortest path with an interior point
  localparam logic [SW-1:0] SUM_SAT = SW'({gps_pkg::SUM_W{1'b1}});

  typedef enum logic [3:0] {
    S_LOAD,   // taking points
    S_SW0,    // sweep start: read point 0
    S_SW1,    // read point 1, latch left neighbour
    S_SW2,    // latch current point
    S_RD,     // read right neighbour and original of the current point
    S_MD,     // data term
    S_MS,     // smoothing term
    S_SAT,    // sum and saturate
    S_DEL,    // absolute change
    S_ACC,    // accumulate change, next coordinate
    S_WR,     // write back, slide the window
    S_CHK,    // convergence and sweep limit check
    S_OUT     // stream the points out
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [gps_pkg::WEIGHT_W-1:0] data_weight_r;
  logic [gps_pkg::WEIGHT_W-1:0] smooth_weight_r;
  logic [gps_pkg::TOL_W-1:0]    stop_tol_r;
  logic [gps_pkg::LIMIT_W-1:0]  sweep_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_weight_r   <= gps_pkg::DATA_WEIGHT_RST;
      smooth_weight_r <= gps_pkg::SMOOTH_WEIGHT_RST;
      stop_tol_r      <= gps_pkg::STOP_TOL_RST;
      sweep_limit_r   <= gps_pkg::SWEEP_LIMIT_RST;
    end else if (cfg_we) begin
      case (gps_pkg::cfg_reg_t'(cfg_index))
        gps_pkg::REG_DATA_WEIGHT:   data_weight_r   <= cfg_wdata[gps_pkg::WEIGHT_W-1:0];
        gps_pkg::REG_SMOOTH_WEIGHT: smooth_weight_r <= cfg_wdata[gps_pkg::WEIGHT_W-1:0];
        gps_pkg::REG_STOP_TOL:      stop_tol_r      <= cfg_wdata[gps_pkg::TOL_W-1:0];
        gps_pkg::REG_SWEEP_LIMIT:   sweep_limit_r   <= cfg_wdata[gps_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Point stores: the original path and the working copy, one point per word.
  // --------------------------------------------------------------------------
  logic [MW-1:0] org_mem [MAX_POINTS];
  logic [MW-1:0] wk_mem  [MAX_POINTS];
  logic [MW-1:0] org_rd_r;
  logic [MW-1:0] wk_rd_r;

  logic          load_wr;
  logic          org_re;
  logic [CA-1:0] org_raddr;
  logic          wk_we;
  logic [CA-1:0] wk_waddr;
  logic [MW-1:0] wk_wdata;
  logic          wk_re;
  logic [CA-1:0] wk_raddr;

  always_ff @(posedge clk) begin
    if (load_wr) begin
      org_mem[wk_waddr] <= {in_coord_b, in_coord_a};
    end
    if (org_re) begin
      org_rd_r <= org_mem[org_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wk_we) begin
      wk_mem[wk_waddr] <= wk_wdata;
    end
    if (wk_re) begin
      wk_rd_r <= wk_mem[wk_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;
  logic [CW-1:0]               pcnt_r, pcnt_nxt;
  logic [CA-1:0]               i_r, i_nxt;
  logic [CA-1:0]               k_r, k_nxt;
  logic                        j_r, j_nxt;
  logic [gps_pkg::LIMIT_W-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [gps_pkg::SUM_W-1:0]   change_r, change_nxt;
  logic                        capped_r, capped_nxt;
  logic signed [CB-1:0]        prev_a_r, prev_a_nxt, prev_b_r, prev_b_nxt;
  logic signed [CB-1:0]        cur_a_r, cur_a_nxt, cur_b_r, cur_b_nxt;
  logic signed [CB-1:0]        new_a_r, new_a_nxt, new_b_r, new_b_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        accept;
  logic                        out_last;
  logic                        over_tol;
  logic [gps_pkg::LIMIT_W-1:0] sweep_inc;
  logic [gps_pkg::LIMIT_W-1:0] limit;
  logic [SW-1:0]               acc_sum;

  gps_pkg::mac_ctrl_t          mac_ctrl;
  logic signed [CB-1:0]        mac_cur, mac_orig, mac_prev, mac_next;
  logic signed [CB-1:0]        mac_new;
  logic [CB:0]                 mac_abs;

  assign accept    = start && !busy;
  assign load_wr   = accept && (pcnt_r < CW'(MAX_POINTS));
  assign out_last  = ((CW'(k_r) + CW'(1)) == pcnt_r);
  assign over_tol  = (change_r >= gps_pkg::SUM_W'(stop_tol_r));
  assign sweep_inc = sweep_cnt_r + gps_pkg::LIMIT_W'(1);
  // A zero limit still runs one sweep.
  assign limit     = (sweep_limit_r == '0) ? gps_pkg::LIMIT_W'(1) : sweep_limit_r;
  assign acc_sum   = SW'(change_r) + SW'(mac_abs);

  // Coordinate a is updated before coordinate b of the same point.
  assign mac_cur  = j_r ? cur_b_r  : cur_a_r;
  assign mac_prev = j_r ? prev_b_r : prev_a_r;
  assign mac_orig = j_r ? $signed(org_rd_r[MW-1:CB]) : $signed(org_rd_r[CB-1:0]);
  assign mac_next = j_r ? $signed(wk_rd_r[MW-1:CB])  : $signed(wk_rd_r[CB-1:0]);

  always_comb begin
    state_nxt     = state_r;
    pcnt_nxt      = pcnt_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    sweep_cnt_nxt = sweep_cnt_r;
    change_nxt    = change_r;
    capped_nxt    = capped_r;
    prev_a_nxt    = prev_a_r;
    prev_b_nxt    = prev_b_r;
    cur_a_nxt     = cur_a_r;
    cur_b_nxt     = cur_b_r;
    new_a_nxt     = new_a_r;
    new_b_nxt     = new_b_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;

    wk_we     = 1'b0;
    wk_waddr  = pcnt_r[CA-1:0];
    wk_wdata  = {in_coord_b, in_coord_a};
    wk_re     = 1'b0;
    wk_raddr  = i_r;
    org_re    = 1'b0;
    org_raddr = i_r;

    mac_ctrl.op            = gps_pkg::MAC_HOLD;
    mac_ctrl.data_weight   = data_weight_r;
    mac_ctrl.smooth_weight = smooth_weight_r;

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (load_wr) begin
            wk_we    = 1'b1;
            pcnt_nxt = pcnt_r + CW'(1);
          end
          if (in_final_point) begin
            sweep_cnt_nxt = '0;
            state_nxt     = S_SW0;
          end
        end
      end
      S_SW0: begin
        change_nxt = '0;
        if (pcnt_r < CW'(MinPathLen)) begin
          state_nxt = S_CHK;
        end else begin
          wk_re     = 1'b1;
          wk_raddr  = '0;
          state_nxt = S_SW1;
        end
      end
      S_SW1: begin
        wk_re      = 1'b1;
        wk_raddr   = CA'(1);
        prev_a_nxt = $signed(wk_rd_r[CB-1:0]);
        prev_b_nxt = $signed(wk_rd_r[MW-1:CB]);
        state_nxt  = S_SW2;
      end
      S_SW2: begin
        cur_a_nxt = $signed(wk_rd_r[CB-1:0]);
        cur_b_nxt = $signed(wk_rd_r[MW-1:CB]);
        i_nxt     = CA'(1);
        state_nxt = S_RD;
      end
      S_RD: begin
        wk_re     = 1'b1;
        wk_raddr  = i_r + CA'(1);
        org_re    = 1'b1;
        j_nxt     = 1'b0;
        state_nxt = S_MD;
      end
      S_MD: begin
        mac_ctrl.op = gps_pkg::MAC_DATA;
        state_nxt   = S_MS;
      end
      S_MS: begin
        mac_ctrl.op = gps_pkg::MAC_SMOOTH;
        state_nxt   = S_SAT;
      end
      S_SAT: begin
        mac_ctrl.op = gps_pkg::MAC_SAT;
        state_nxt   = S_DEL;
      end
      S_DEL: begin
        mac_ctrl.op = gps_pkg::MAC_DELTA;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        change_nxt = (acc_sum > SUM_SAT) ? SUM_SAT[gps_pkg::SUM_W-1:0]
                                         : acc_sum[gps_pkg::SUM_W-1:0];
        if (j_r) begin
          new_b_nxt = mac_new;
          state_nxt = S_WR;
        end else begin
          new_a_nxt = mac_new;
          j_nxt     = 1'b1;
          state_nxt = S_MD;
        end
      end
      S_WR: begin
        wk_we      = 1'b1;
        wk_waddr   = i_r;
        wk_wdata   = {new_b_r, new_a_r};
        prev_a_nxt = new_a_r;
        prev_b_nxt = new_b_r;
        cur_a_nxt  = $signed(wk_rd_r[CB-1:0]);
        cur_b_nxt  = $signed(wk_rd_r[MW-1:CB]);
        i_nxt      = i_r + CA'(1);
        if (((CW+1)'(i_r) + (CW+1)'(2)) < (CW+1)'(pcnt_r)) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        sweep_cnt_nxt = sweep_inc;
        if (over_tol && (sweep_inc < limit)) begin
          state_nxt = S_SW0;
        end else begin
          capped_nxt = over_tol;
          k_nxt      = '0;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        wk_re         = 1'b1;
        wk_raddr      = k_r;
        out_valid_nxt = 1'b1;
        out_last_nxt  = out_last;
        if (out_last) begin
          pcnt_nxt  = '0;
          state_nxt = S_LOAD;
        end else begin
          k_nxt = k_r + CA'(1);
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      pcnt_r      <= '0;
      i_r         <= '0;
      k_r         <= '0;
      j_r         <= 1'b0;
      sweep_cnt_r <= '0;
      change_r    <= '0;
      capped_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pcnt_r      <= pcnt_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      change_r    <= change_nxt;
      capped_r    <= capped_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    prev_a_r <= prev_a_nxt;
    prev_b_r <= prev_b_nxt;
    cur_a_r  <= cur_a_nxt;
    cur_b_r  <= cur_b_nxt;
    new_a_r  <= new_a_nxt;
    new_b_r  <= new_b_nxt;
  end

  // --------------------------------------------------------------------------
  // Shared multiply and update unit
  // --------------------------------------------------------------------------
  gps_mac #(
    .COORD_BITS (COORD_BITS)
  ) u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .cur       (mac_cur),
    .orig      (mac_orig),
    .prev      (mac_prev),
    .next      (mac_next),
    .new_coord (mac_new),
    .abs_delta (mac_abs)
  );

  // --------------------------------------------------------------------------
  // Outputs: the registered read word of the working store is the result
  // payload, in the cycle after the read that the output phase issues.
  // --------------------------------------------------------------------------
  assign busy         = (state_r != S_LOAD);
  assign out_valid    = out_valid_r;
  assign out_smooth_a = $signed(wk_rd_r[CB-1:0]);
  assign out_smooth_b = $signed(wk_rd_r[MW-1:CB]);
  assign out_run_end  = out_last_r;
  assign out_cap_hit  = capped_r;

endmodule
`default_nettype wire

@@ rtl/gps_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gps_mac - shared multiply and update unit
// One weight multiplier reused for the data term and the smoothing term,
// followed by saturation and the absolute change of one coordinate.
// ----------------------------------------------------------------------------
module gps_mac #(
  parameter int COORD_BITS = 32
) (
  input  wire                           clk,
  input  wire gps_pkg::mac_ctrl_t       ctrl,
  input  wire logic signed [COORD_BITS-1:0] cur,
  input  wire logic signed [COORD_BITS-1:0] orig,
  input  wire logic signed [COORD_BITS-1:0] prev,
  input  wire logic signed [COORD_BITS-1:0] next,
  output logic signed [COORD_BITS-1:0]  new_coord,
  output logic        [COORD_BITS:0]    abs_delta
);

  localparam int XW = COORD_BITS + 3;               // multiplier operand
  localparam int WW = gps_pkg::WEIGHT_W + 1;        // weight with a zero sign bit
  localparam int PW = XW + WW;                      // full product
  localparam int TW = PW - gps_pkg::FRAC_BITS;      // floored product
  localparam int VW = XW + 3;                       // update sum
  localparam int DW = COORD_BITS + 1;               // change

  localparam logic signed [VW-1:0] CMAX =
    {{(VW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [VW-1:0] CMIN =
    {{(VW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  logic signed [XW-1:0] diff;
  logic signed [XW-1:0] nbr;
  logic signed [XW-1:0] x_op;
  logic [gps_pkg::WEIGHT_W-1:0] w_op;
  logic signed [WW-1:0] w_ext;
  logic signed [PW-1:0] prod;
  logic signed [TW-1:0] term;
  logic signed [VW-1:0] upd;
  logic signed [DW-1:0] dlt;

  logic signed [PW-1:0]         mul_r;
  logic signed [VW-1:0]         sum_r;
  logic signed [COORD_BITS-1:0] newv_r;
  logic        [DW-1:0]         abs_r;

  assign diff  = XW'(orig) - XW'(cur);
  assign nbr   = XW'(prev) + XW'(next) - (XW'(cur) <<< 1);
  assign x_op  = (ctrl.op == gps_pkg::MAC_DATA) ? diff : nbr;
  assign w_op  = (ctrl.op == gps_pkg::MAC_DATA) ? ctrl.data_weight : ctrl.smooth_weight;
  assign w_ext = $signed({1'b0, w_op});
  assign prod  = PW'(w_ext) * PW'(x_op);
  // An arithmetic drop of the fraction bits is the floor of the weighted value.
  assign term  = $signed(mul_r[PW-1:gps_pkg::FRAC_BITS]);
  assign upd   = sum_r + VW'(term);
  assign dlt   = DW'(newv_r) - DW'(cur);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      gps_pkg::MAC_DATA: begin
        mul_r <= prod;
      end
      gps_pkg::MAC_SMOOTH: begin
        sum_r <= VW'(cur) + VW'(term);
        mul_r <= prod;
      end
      gps_pkg::MAC_SAT: begin
        if (upd > CMAX) begin
          newv_r <= CMAX[COORD_BITS-1:0];
        end else if (upd < CMIN) begin
          newv_r <= CMIN[COORD_BITS-1:0];
        end else begin
          newv_r <= upd[COORD_BITS-1:0];
        end
      end
      gps_pkg::MAC_DELTA: begin
        abs_r <= dlt[DW-1] ? DW'(-dlt) : DW'(dlt);
      end
      default: begin
      end
    endcase
  end

  assign new_coord = newv_r;
  assign abs_delta = abs_r;

endmodule
`default_nettype wire

@@ tb/tb_gradient_path_smoother_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gradient_path_smoother_top - self-checking bench for the path smoother
// Paths are sent one point per beat. An independent Q15.16 Gauss-Seidel model
// predicts every smoothed point, and each result beat is checked in order
// against it under several weight, tolerance and sweep cap settings.
// ----------------------------------------------------------------------------
module tb_gradient_path_smoother_top;

  localparam int     MAX_PTS   = 64;
  localparam int     COORD_W   = 32;
  localparam longint COORD_HI  = 64'sd2147483647;
  localparam longint COORD_LO  = -64'sd2147483648;
  localparam longint SUM_CAP   = (64'sd1 <<< gps_pkg::SUM_W) - 1;
  // Random settings keep the sweep cap low, so that long paths stay affordable.
  localparam int     RAND_SWEEPS = 24;

  // One input beat: a point of the path and the flag that closes the path.
  typedef struct packed {
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
    logic               is_last;
  } path_point_t;

  // One result beat as the smoother should issue it.
  typedef struct packed {
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
    logic               run_end;
    logic               cap_hit;
  } smoothed_pt_t;

  // Shapes of generated paths: full-range noise, a gentle random walk (which
  // converges and exercises the tolerance test), and saturation-prone extremes.
  typedef enum int {
    STYLE_WIDE,
    STYLE_WALK,
    STYLE_EXTREME
  } path_style_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the ports of the block. Every input is known from time 0.
  // --------------------------------------------------------------------------
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic [COORD_W-1:0]  in_coord_a     = '0;
  logic [COORD_W-1:0]  in_coord_b     = '0;
  logic                in_final_point = 1'b0;
  logic                cfg_we         = 1'b0;
  gps_pkg::cfg_reg_t   cfg_index      = gps_pkg::REG_DATA_WEIGHT;
  logic [gps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                busy;
  logic                out_valid;
  logic [COORD_W-1:0]  out_smooth_a;
  logic [COORD_W-1:0]  out_smooth_b;
  logic                out_run_end;
  logic                out_cap_hit;

  always #6 clk = ~clk;

  gradient_path_smoother_top #(
    .MAX_POINTS (MAX_PTS),
    .COORD_BITS (COORD_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_coord_a     (in_coord_a),
    .in_coord_b     (in_coord_b),
    .in_final_point (in_final_point),
    .out_valid      (out_valid),
    .out_smooth_a   (out_smooth_a),
    .out_smooth_b   (out_smooth_b),
    .out_run_end    (out_run_end),
    .out_cap_hit    (out_cap_hit),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Bench state. The point queue feeds the driver; the smoothed queue holds
  // the predicted result beats, oldest first.
  // --------------------------------------------------------------------------
  path_point_t   point_q[$];
  smoothed_pt_t  smoothed_q[$];
  path_point_t   drv_pt;
  smoothed_pt_t  want;

  int unsigned   beats_sent    = 0;   // beats presented by the driver
  int unsigned   beats_taken   = 0;   // beats accepted by the block
  int unsigned   beats_out     = 0;   // result beats seen
  int unsigned   fail_cnt      = 0;
  int unsigned   paths_done    = 0;
  int unsigned   sweeps_total  = 0;
  int unsigned   capped_paths  = 0;
  int unsigned   settings_used = 1;   // the reset values count as the first
  int            send_idle_pct = 0;

  // Own copy of the configuration registers, starting from their reset values.
  bit [gps_pkg::WEIGHT_W-1:0] dweight_reg = gps_pkg::DATA_WEIGHT_RST;
  bit [gps_pkg::WEIGHT_W-1:0] sweight_reg = gps_pkg::SMOOTH_WEIGHT_RST;
  bit [gps_pkg::TOL_W-1:0]    tol_reg     = gps_pkg::STOP_TOL_RST;
  bit [gps_pkg::LIMIT_W-1:0]  limit_reg   = gps_pkg::SWEEP_LIMIT_RST;

  // Own copy of the point stores. Only entries of the current path are read.
  bit signed [COORD_W-1:0] orig_pt [MAX_PTS][2];
  bit signed [COORD_W-1:0] work_pt [MAX_PTS][2];
  int                      pts_loaded = 0;

  // --------------------------------------------------------------------------
  // Smoothing predictor.
  // --------------------------------------------------------------------------

  // floor(w * x / 2^16) for an unsigned Q0.16 weight. The product stays well
  // inside 64 bits, and the arithmetic shift rounds towards minus infinity.
  function automatic longint weigh_q16(bit [gps_pkg::WEIGHT_W-1:0] w, longint x);
    longint prod;
    prod = longint'({48'd0, w}) * x;
    return prod >>> gps_pkg::FRAC_BITS;
  endfunction

  // Stores one accepted point. The last point of a path runs the sweeps and
  // queues one predicted beat per stored point.
  task automatic take_point(input bit signed [COORD_W-1:0] pa, pb, input bit is_last);
    int           n;
    int           lim;
    int           sweeps;
    longint       change;
    longint       cur;
    longint       dv;
    longint       nb;
    longint       nv;
    bit           capped;
    smoothed_pt_t sp;
    // Points beyond the store depth are dropped; a closing point still counts.
    if (pts_loaded < MAX_PTS) begin
      orig_pt[pts_loaded][0] = pa;
      orig_pt[pts_loaded][1] = pb;
      work_pt[pts_loaded][0] = pa;
      work_pt[pts_loaded][1] = pb;
      pts_loaded++;
    end
    if (is_last) begin
      n      = pts_loaded;
      lim    = (limit_reg == 0) ? 1 : int'(limit_reg);
      sweeps = 0;
      // The first sweep always runs. Updates are in place, so the left
      // neighbour is already this sweep's value and the right one is not.
      do begin
        change = 0;
        for (int i = 1; i + 1 < n; i++) begin
          for (int j = 0; j < 2; j++) begin
            cur = work_pt[i][j];
            dv  = orig_pt[i][j];
            dv  = dv - cur;
            nb  = work_pt[i-1][j];
            nb  = nb + work_pt[i+1][j] - 2 * cur;
            nv  = cur + weigh_q16(dweight_reg, dv) + weigh_q16(sweight_reg, nb);
            if (nv > COORD_HI) nv = COORD_HI;
            else if (nv < COORD_LO) nv = COORD_LO;
            change += (nv > cur) ? nv - cur : cur - nv;
            if (change > SUM_CAP) change = SUM_CAP;
            work_pt[i][j] = nv[COORD_W-1:0];
          end
        end
        sweeps++;
      end while (change >= longint'(tol_reg) && sweeps < lim);
      capped = (change >= longint'(tol_reg));

      for (int k = 0; k < n; k++) begin
        sp.a       = work_pt[k][0];
        sp.b       = work_pt[k][1];
        sp.run_end = (k == n - 1);
        sp.cap_hit = capped;
        smoothed_q.insert(smoothed_q.size(), sp);
      end
      paths_done++;
      sweeps_total += sweeps;
      capped_paths += capped;
      pts_loaded    = 0;
    end
  endtask

  task automatic log_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] ERROR %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge. A beat stays presented until
  // the monitor has seen it accepted; only then is the next one considered,
  // with a random idle gap according to the current idle percentage.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (beats_taken == beats_sent) begin
      if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_pt          = point_q.pop_front();
        start          <= 1'b1;
        in_coord_a     <= drv_pt.a;
        in_coord_b     <= drv_pt.b;
        in_final_point <= drv_pt.is_last;
        beats_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. On each rising edge it checks a result beat against the oldest
  // prediction, then feeds an accepted input beat to the predictor. A result
  // can never belong to a beat accepted at the same edge, so the order of the
  // two steps does not matter for the queue.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid !== 1'b0) begin
        if (smoothed_q.size() == 0) begin
          log_fail($sformatf("result beat with nothing predicted: a=%0d b=%0d end=%b cap=%b",
                             $signed(out_smooth_a), $signed(out_smooth_b),
                             out_run_end, out_cap_hit));
        end else begin
          want = smoothed_q.pop_front();
          if (out_smooth_a !== want.a || out_smooth_b !== want.b ||
              out_run_end !== want.run_end || out_cap_hit !== want.cap_hit) begin
            log_fail($sformatf({"result beat %0d: expected a=%0d b=%0d end=%b cap=%b,",
                                " got a=%0d b=%0d end=%b cap=%b"}, beats_out,
                               $signed(want.a), $signed(want.b), want.run_end,
                               want.cap_hit, $signed(out_smooth_a),
                               $signed(out_smooth_b), out_run_end, out_cap_hit));
          end
        end
        beats_out++;
      end
      if (start && busy === 1'b0) begin
        take_point(in_coord_a, in_coord_b, in_final_point);
        beats_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_point(input bit [COORD_W-1:0] pa, pb, input bit is_last);
    path_point_t p;
    p.a       = pa;
    p.b       = pb;
    p.is_last = is_last;
    point_q.insert(point_q.size(), p);
  endtask

  function automatic bit [COORD_W-1:0] extreme_coord();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Queues a whole path; only its last point carries the closing flag.
  task automatic queue_path(input int len, input path_style_t style);
    bit [COORD_W-1:0] pa;
    bit [COORD_W-1:0] pb;
    pa = $urandom_range(0, 1 << 25) - (1 << 24);
    pb = $urandom_range(0, 1 << 25) - (1 << 24);
    for (int k = 0; k < len; k++) begin
      case (style)
        STYLE_WIDE: begin
          pa = $urandom;
          pb = $urandom;
        end
        STYLE_WALK: begin
          // Wrapping 32-bit sums give the two's complement step directly.
          pa = pa + ($urandom_range(0, 1 << 19) - (1 << 18));
          pb = pb + ($urandom_range(0, 1 << 19) - (1 << 18));
        end
        default: begin
          pa = extreme_coord();
          pb = extreme_coord();
        end
      endcase
      push_point(pa, pb, k == len - 1);
    end
  endtask

  // Waits until every beat is taken, every prediction is met and the block
  // has dropped busy, then gives it a few more cycles before anything else.
  task automatic settle();
    while (point_q.size() != 0 || beats_taken != beats_sent ||
           smoothed_q.size() != 0 || busy !== 1'b0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // A register write lasts one cycle; the bench copy follows at once, which
  // is safe because writes only happen while the block is idle.
  task automatic set_reg(input gps_pkg::cfg_reg_t idx,
                         input bit [gps_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      gps_pkg::REG_DATA_WEIGHT:   dweight_reg = val[gps_pkg::WEIGHT_W-1:0];
      gps_pkg::REG_SMOOTH_WEIGHT: sweight_reg = val[gps_pkg::WEIGHT_W-1:0];
      gps_pkg::REG_STOP_TOL:      tol_reg     = val[gps_pkg::TOL_W-1:0];
      gps_pkg::REG_SWEEP_LIMIT:   limit_reg   = val[gps_pkg::LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input bit [gps_pkg::WEIGHT_W-1:0] wd, ws,
                                input bit [gps_pkg::TOL_W-1:0] tol,
                                input bit [gps_pkg::LIMIT_W-1:0] lim);
    set_reg(gps_pkg::REG_DATA_WEIGHT,   {16'd0, wd});
    set_reg(gps_pkg::REG_SMOOTH_WEIGHT, {16'd0, ws});
    set_reg(gps_pkg::REG_STOP_TOL,      tol);
    set_reg(gps_pkg::REG_SWEEP_LIMIT,   {16'd0, lim});
    settings_used++;
  endtask

  // Random settings: sometimes the usual weights, sometimes an extreme weight,
  // a tolerance anywhere from zero to the maximum and a modest sweep cap.
  task automatic pick_settings();
    bit [gps_pkg::WEIGHT_W-1:0] wd;
    bit [gps_pkg::WEIGHT_W-1:0] ws;
    bit [gps_pkg::TOL_W-1:0]    tol;
    case ($urandom_range(3))
      0: begin
        wd = gps_pkg::DATA_WEIGHT_RST;
        ws = gps_pkg::SMOOTH_WEIGHT_RST;
      end
      1: begin
        wd = gps_pkg::WEIGHT_W'($urandom_range(0, 65535));
        ws = gps_pkg::WEIGHT_W'($urandom_range(0, 65535));
      end
      2: begin
        wd = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        ws = gps_pkg::WEIGHT_W'($urandom_range(0, 65535));
      end
      default: begin
        wd = gps_pkg::WEIGHT_W'($urandom_range(0, 65535));
        ws = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      end
    endcase
    case ($urandom_range(5))
      0:       tol = '0;
      1:       tol = '1;
      2:       tol = $urandom;
      default: tol = $urandom_range(0, 1 << 20);
    endcase
    apply_settings(wd, ws, tol, gps_pkg::LIMIT_W'($urandom_range(1, RAND_SWEEPS)));
  endtask

  // Random paths, mostly short, a few long, and now and then one that runs
  // past the store depth, whose dropped points count as one towards the quota.
  task automatic run_random_phase(input int idle_pct, input int quota);
    int          got;
    int          len;
    int          r;
    path_style_t style;
    send_idle_pct = idle_pct;
    got = 0;
    while (got < quota) begin
      r = $urandom_range(99);
      if (r < 86)      len = $urandom_range(1, 8);
      else if (r < 97) len = $urandom_range(9, MAX_PTS);
      else             len = $urandom_range(MAX_PTS + 1, MAX_PTS + 6);
      r = $urandom_range(9);
      if (r < 4)       style = STYLE_WALK;
      else if (r < 8)  style = STYLE_WIDE;
      else             style = STYLE_EXTREME;
      queue_path(len, style);
      got += (len > MAX_PTS) ? MAX_PTS + 1 : len;
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings allow 65535 sweeps, so only paths that settle at once
    // are used here: a lone point, a pair, and an evenly spaced straight line
    // whose interior point has no pull in any direction.
    push_point(32'h7fff_ffff, 32'h8000_0000, 1'b1);
    push_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    push_point(32'h0000_0000, 32'hffff_ffff, 1'b1);
    push_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_point(32'h0001_0000, 32'hffff_0000, 1'b0);
    push_point(32'h0002_0000, 32'hfffe_0000, 1'b1);
    settle();

    // Zero tolerance with a cap of one sweep: the cap flag must be raised even
    // on a pair with no interior points. A zigzag between the extremes with
    // full smoothing weight drives both coordinates into saturation.
    apply_settings(16'h0000, 16'hffff, 32'd0, 16'd1);
    push_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    push_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    push_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    push_point(32'h1234_5678, 32'hedcb_a988, 1'b0);
    push_point(32'h8765_4321, 32'h789a_bcde, 1'b1);
    settle();

    // A sweep limit of zero behaves as a single sweep.
    apply_settings(16'hffff, 16'h0000, 32'd0, 16'd0);
    queue_path(4, STYLE_EXTREME);
    settle();

    // Largest tolerance: the first sweep runs regardless and then stops.
    apply_settings(gps_pkg::DATA_WEIGHT_RST, gps_pkg::SMOOTH_WEIGHT_RST, 32'hffff_ffff,
                   gps_pkg::SWEEP_LIMIT_RST);
    queue_path(5, STYLE_WALK);
    settle();

    // Random phases with different sender idle rates. The first one opens
    // with a path longer than the stores hold. Each phase ends with a full
    // drain, so the sender also waits for every result at least once.
    pick_settings();
    queue_path(MAX_PTS + 3, STYLE_WALK);
    run_random_phase(0, 80);
    pick_settings();
    run_random_phase(57, 90);
    pick_settings();
    run_random_phase(12, 90);
    pick_settings();
    run_random_phase(0, 80);

    $display("Sent %0d points in %0d paths under %0d register settings; checked %0d results.",
             beats_taken, paths_done, settings_used, beats_out);
    $display("Predicted %0d sweeps in all, %0d paths stopped at the sweep cap, %0d mismatches.",
             sweeps_total, capped_paths, fail_cnt);
    if (fail_cnt == 0 && smoothed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run of this sequence.
  initial begin
    #30ms;
    $display("Run timed out with %0d results still predicted.", smoothed_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
